// ===== hdl/mcs_pkg.sv =====
// Package: shared types and constants for the melody and click sequencer.
`default_nettype none

package mcs_pkg;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_PULSE = 2'd1,
		FUNC_WRITE = 2'd2,
		FUNC_START = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		REG_LED_CLICK_EN = 2'd0,
		REG_SPK_CLICK_EN = 2'd1,
		REG_CLICK_LEN    = 2'd2,
		REG_CLICK_HZ     = 2'd3
	} cfg_reg_t;

	localparam int CFG_DATA_W = 15;

	// reset values of the configuration registers
	localparam logic [7:0]  CLICK_LEN_RESET = 8'd4;
	localparam logic [14:0] CLICK_HZ_RESET  = 15'd5000;

	localparam logic [14:0] MAX_TONE_HZ  = 15'd20000;
	localparam logic [24:0] MAX_TONE_MHZ = 25'd20000000;

	// millihertz to hertz: x / 1000 == (x * ceil(2^35 / 1000)) >> 35, exact for x < 2^25
	localparam logic [25:0] FREQ_RECIP  = 26'd34359739;
	localparam int          RECIP_SHIFT = 35;

	typedef struct packed {
		func_t       func;
		logic [3:0]  entry_index;
		logic [24:0] entry_freq_mhz;
		logic        entry_volume;
		logic [15:0] entry_duration;
	} item_t;

	typedef struct packed {
		logic        tone_enable;
		logic [14:0] tone_freq_hz;
		logic        drive_push_pull;
		logic        led_on;
		logic        melody_busy;
	} result_t;

	// melody entry as kept in the store: frequency already in hertz and saturated
	typedef struct packed {
		logic [14:0] hz;
		logic        nonzero;
		logic        volume;
		logic [15:0] duration;
	} entry_t;

	typedef struct packed {
		logic                  we;
		cfg_reg_t              index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_write_t;

endpackage

`default_nettype wire

// ===== hdl/mcs_stream_if.sv =====
// Interface: valid/ready stream channel carrying one payload of type T.
`default_nettype none

interface mcs_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/mcs_ram.sv =====
// Generic single-write, single-read RAM with registered, write-first read.
`default_nettype none

module mcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (we && waddr == raddr) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/mcs_core.sv =====
// Core: melody and click state update, melody store, configuration registers.
`default_nettype none

module mcs_core #(
	parameter int MELODY_DEPTH = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                valid_s1,
	input  wire mcs_pkg::item_t      item_s1,
	input  wire mcs_pkg::cfg_write_t cfg,
	output mcs_pkg::result_t         result
);

	localparam int AW = $clog2(MELODY_DEPTH);
	localparam int PW = $clog2(MELODY_DEPTH + 1);
	localparam int IW = (PW > 4) ? PW : 4;
	localparam int EW = $bits(mcs_pkg::entry_t);

	logic        led_en_q, led_en_d;
	logic        spk_en_q, spk_en_d;
	logic [7:0]  click_len_q, click_len_d;
	logic [14:0] click_hz_q, click_hz_d;

	logic [PW-1:0] pos_q, pos_d;
	logic [15:0]   note_left_q, note_left_d;
	logic          running_q, running_d;
	logic [7:0]    click_left_q, click_left_d;
	logic          pending_q, pending_d;
	logic          tone_q, tone_d;
	logic [14:0]   freq_q, freq_d;
	logic          drive_q, drive_d;
	logic          led_q, led_d;

	// store write path: convert millihertz to saturated hertz before writing
	logic [IW-1:0]        idx_ext;
	logic                 wr_en;
	logic [50:0]          prod;
	mcs_pkg::entry_t      wentry;
	mcs_pkg::entry_t      rentry;
	logic [EW-1:0]        rdata;

	assign idx_ext = IW'(item_s1.entry_index);
	assign wr_en   = valid_s1 && item_s1.func == mcs_pkg::FUNC_WRITE
		&& idx_ext < IW'(MELODY_DEPTH);
	assign prod    = item_s1.entry_freq_mhz * mcs_pkg::FREQ_RECIP;

	always_comb begin
		wentry.hz       = (item_s1.entry_freq_mhz >= mcs_pkg::MAX_TONE_MHZ)
			? mcs_pkg::MAX_TONE_HZ : prod[mcs_pkg::RECIP_SHIFT +: 15];
		wentry.nonzero  = item_s1.entry_freq_mhz != '0;
		wentry.volume   = item_s1.entry_volume;
		wentry.duration = item_s1.entry_duration;
	end

	// read address follows the next position, so the entry is ready for the next tick
	mcs_ram #(
		.WIDTH(EW),
		.DEPTH(MELODY_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(idx_ext[AW-1:0]),
		.wdata(wentry),
		.raddr(pos_d[AW-1:0]),
		.rdata(rdata)
	);

	assign rentry = mcs_pkg::entry_t'(rdata);

	always_comb begin
		led_en_d     = led_en_q;
		spk_en_d     = spk_en_q;
		click_len_d  = click_len_q;
		click_hz_d   = click_hz_q;
		pos_d        = pos_q;
		note_left_d  = note_left_q;
		running_d    = running_q;
		click_left_d = click_left_q;
		pending_d    = pending_q;
		tone_d       = tone_q;
		freq_d       = freq_q;
		drive_d      = drive_q;
		led_d        = led_q;

		if (valid_s1) begin
			unique case (item_s1.func)
				mcs_pkg::FUNC_TICK: begin
					if (running_q) begin
						if (note_left_q == '0) begin
							if (pos_q >= PW'(MELODY_DEPTH) || rentry.duration == '0) begin
								// end of melody: LED and click countdown untouched
								tone_d    = 1'b0;
								drive_d   = 1'b0;
								running_d = 1'b0;
								pos_d     = '0;
								pending_d = 1'b0;
							end else begin
								if (rentry.nonzero) begin
									freq_d  = rentry.hz;
									tone_d  = 1'b1;
									drive_d = rentry.volume;
								end else begin
									tone_d  = 1'b0;
									drive_d = 1'b0;
								end
								note_left_d = rentry.duration;
								pos_d       = pos_q + PW'(1);
							end
						end else begin
							note_left_d = note_left_q - 16'd1;
						end
					end else if (click_left_q != '0) begin
						click_left_d = click_left_q - 8'd1;
						if (click_left_q == 8'd1) begin
							tone_d  = 1'b0;
							drive_d = 1'b0;
							led_d   = 1'b0;
						end
					end else if (pending_q) begin
						pending_d = 1'b0;
						if (spk_en_q) begin
							freq_d  = (click_hz_q > mcs_pkg::MAX_TONE_HZ)
								? mcs_pkg::MAX_TONE_HZ : click_hz_q;
							tone_d  = 1'b1;
							drive_d = 1'b1;
						end
						if (led_en_q) begin
							led_d = 1'b1;
						end
						click_left_d = (click_len_q == '0) ? 8'd1 : click_len_q;
					end
				end
				mcs_pkg::FUNC_PULSE: begin
					if (led_en_q || spk_en_q) begin
						pending_d = 1'b1;
					end
				end
				mcs_pkg::FUNC_WRITE: begin
				end
				mcs_pkg::FUNC_START: begin
					pos_d       = '0;
					note_left_d = '0;
					running_d   = 1'b1;
				end
				default: begin
				end
			endcase
		end

		if (cfg.we) begin
			unique case (cfg.index)
				mcs_pkg::REG_LED_CLICK_EN: led_en_d    = cfg.data[0];
				mcs_pkg::REG_SPK_CLICK_EN: spk_en_d    = cfg.data[0];
				mcs_pkg::REG_CLICK_LEN:    click_len_d = cfg.data[7:0];
				mcs_pkg::REG_CLICK_HZ:     click_hz_d  = cfg.data[14:0];
				default: begin
				end
			endcase
			if ((cfg.index == mcs_pkg::REG_LED_CLICK_EN || cfg.index == mcs_pkg::REG_SPK_CLICK_EN)
				&& !led_en_d && !spk_en_d) begin
				pending_d    = 1'b0;
				click_left_d = '0;
				tone_d       = 1'b0;
				drive_d      = 1'b0;
				led_d        = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_en_q     <= 1'b0;
			spk_en_q     <= 1'b0;
			click_len_q  <= mcs_pkg::CLICK_LEN_RESET;
			click_hz_q   <= mcs_pkg::CLICK_HZ_RESET;
			pos_q        <= '0;
			note_left_q  <= '0;
			running_q    <= 1'b0;
			click_left_q <= '0;
			pending_q    <= 1'b0;
			tone_q       <= 1'b0;
			freq_q       <= '0;
			drive_q      <= 1'b0;
			led_q        <= 1'b0;
		end else begin
			led_en_q     <= led_en_d;
			spk_en_q     <= spk_en_d;
			click_len_q  <= click_len_d;
			click_hz_q   <= click_hz_d;
			pos_q        <= pos_d;
			note_left_q  <= note_left_d;
			running_q    <= running_d;
			click_left_q <= click_left_d;
			pending_q    <= pending_d;
			tone_q       <= tone_d;
			freq_q       <= freq_d;
			drive_q      <= drive_d;
			led_q        <= led_d;
		end
	end

	// result of the item in stage 1 is the state it leaves behind
	always_comb begin
		result.tone_enable     = tone_d;
		result.tone_freq_hz    = freq_d;
		result.drive_push_pull = drive_d;
		result.led_on          = led_d;
		result.melody_busy     = running_d;
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(MELODY_DEPTH))
		else $error("melody position beyond store depth");

	a_click_needs_mode: assert property (@(posedge clk) disable iff (!arst_n)
		!(led_en_q || spk_en_q) |-> (click_left_q == '0 && !pending_q))
		else $error("click state alive with both click modes off");

	a_melody_stop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(running_q) |-> (pos_q == '0 && !pending_q))
		else $error("melody stopped without rewinding or dropping the click");

endmodule

`default_nettype wire

// ===== hdl/mcs_out_fifo.sv =====
// Two-entry result buffer between the core and the result channel.
`default_nettype none

module mcs_out_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire mcs_pkg::result_t push_data,
	output logic                  can_take,
	mcs_stream_if.source          result
);

	mcs_pkg::result_t mem_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;
	logic             pop;

	assign result.valid = cnt_q != 2'd0;
	assign result.data  = mem_q[rd_q];
	assign pop          = result.valid && result.ready;

	// room for a new transfer once the item ahead of it has been pushed
	assign can_take = (3'(cnt_q) + 3'(push) - 3'(pop)) < 3'd2;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= 2'(3'(cnt_q) + 3'(push) - 3'(pop));
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != 2'd2 || pop))
		else $error("result pushed into a full buffer");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result buffer count out of range");

endmodule

`default_nettype wire

// ===== hdl/melody_and_click_sequencer_top.sv =====
// Top level: input register, sequencer core and result buffer.
//
// Buzzer and LED sequencer driven by a stream of events (millisecond tick, detector pulse,
// melody entry write, melody start). Every transferred item yields exactly one result: the
// output levels after that event. One item is taken every clock cycle while the buffer has
// room; items pass the input register, then the state update into a two-entry result
// buffer. The rate rests on the update reading the melody store through a registered port
// addressed with the next melody position. The store needs no clearing after reset. The user
// must make configuration writes only while no item is in flight; the block does not check.
`default_nettype none

module melody_and_click_sequencer_top #(
	parameter int MELODY_DEPTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [1:0]                     cfg_index,
	input  wire logic [mcs_pkg::CFG_DATA_W-1:0] cfg_data,
	mcs_stream_if.sink                          item,
	mcs_stream_if.source                        result
);

	logic               valid_s1;
	mcs_pkg::item_t     item_s1;
	mcs_pkg::result_t   core_result;
	mcs_pkg::cfg_write_t cfg;
	logic               can_take;
	logic               accept;

	assign item.ready = can_take;
	assign accept     = item.valid && item.ready;

	always_comb begin
		cfg.we    = cfg_we;
		cfg.index = mcs_pkg::cfg_reg_t'(cfg_index);
		cfg.data  = cfg_data;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	mcs_core #(
		.MELODY_DEPTH(MELODY_DEPTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_s1(valid_s1),
		.item_s1 (item_s1),
		.cfg     (cfg),
		.result  (core_result)
	);

	mcs_out_fifo u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (valid_s1),
		.push_data(core_result),
		.can_take (can_take),
		.result   (result)
	);

endmodule

`default_nettype wire
